// ----- rtl/core/xmodem_crc_receiver_top_macros.svh -----
// ---------------------------------------------------------------------------
// xmodem_crc_receiver_top_macros.svh
// Assertion macros shared by the receiver RTL; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef XMODEM_CRC_RECEIVER_TOP_MACROS_SVH
`define XMODEM_CRC_RECEIVER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset
`define XCRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define XCRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define XCRC_ASSERT(label, prop, msg)
`define XCRC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/core/xcrc_pkg.sv -----
// ---------------------------------------------------------------------------
// xcrc_pkg
// Types, protocol codes and the CRC-16 byte update for the XMODEM receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package xcrc_pkg;

    // Event codes on the input channel
    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_BYTE    = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;
    localparam logic [1:0] MODE_FLASH   = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_PROG  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // Session end codes
    localparam logic [1:0] END_DONE      = 2'd0;
    localparam logic [1:0] END_CANCELLED = 2'd1;
    localparam logic [1:0] END_ERRORS    = 2'd2;
    localparam logic [1:0] END_FLASH     = 2'd3;

    // Line bytes
    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_CAN = 8'h18;
    localparam logic [7:0] B_C   = 8'h43;

    // Configuration register indexes
    localparam int          CFG_IDX_W      = 1;
    localparam logic [0:0]  CFG_MAX_ERRORS = 1'd0;
    localparam logic [0:0]  CFG_APP_START  = 1'd1;

    localparam logic [7:0]  MAX_ERRORS_RESET = 8'd3;
    localparam logic [31:0] APP_START_RESET  = 32'h0800_0000;

    localparam int          IDX_W       = 11;
    localparam logic [10:0] SHORT_BYTES = 11'd128;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [7:0]  COUNT_MAX   = 8'hFF;
    localparam int          MAX_RES     = 3;

    // One input item
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic       flash_ok;
    } item_t;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [7:0]  store_byte;
        logic [9:0]  store_offset;
        logic [31:0] program_address;
        logic        program_long;
        logic        erase_first;
        logic [1:0]  end_code;
        logic        last;
    } res_t;

    // All results of one item, in order from entry 0
    typedef struct packed {
        res_t [MAX_RES-1:0] res;
        logic [1:0]         count;
    } batch_t;

    // CRC-16/XMODEM update over one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic res_t mk_tx(input logic [7:0] b);
        res_t r;
        r = '0;
        r.kind = KIND_TX;
        r.tx_byte = b;
        return r;
    endfunction

    function automatic res_t mk_end(input logic [1:0] code);
        res_t r;
        r = '0;
        r.kind = KIND_END;
        r.end_code = code;
        return r;
    endfunction

endpackage

// ----- rtl/core/xcrc_if.sv -----
// ---------------------------------------------------------------------------
// xcrc_if
// Valid/ready channels of the receiver: events in, results out, config.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface xcrc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic       flash_ok;

    modport source (output valid, mode, rx_byte, flash_ok, input ready);
    modport sink   (input valid, mode, rx_byte, flash_ok, output ready);
endinterface

interface xcrc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [7:0]  store_byte;
    logic [9:0]  store_offset;
    logic [31:0] program_address;
    logic        program_long;
    logic        erase_first;
    logic [1:0]  end_code;
    logic        last;

    modport source (output valid, kind, tx_byte, store_byte, store_offset, program_address,
                    program_long, erase_first, end_code, last, input ready);
    modport sink   (input valid, kind, tx_byte, store_byte, store_offset, program_address,
                    program_long, erase_first, end_code, last, output ready);
endinterface

interface xcrc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [xcrc_pkg::CFG_IDX_W-1:0] wr_index;
    logic [31:0]                   wr_data;

    modport source (output valid, wr_index, wr_data, input ready);
    modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

// ----- rtl/core/xcrc_step.sv -----
// ---------------------------------------------------------------------------
// xcrc_step
// Session state and the per-item protocol logic; builds the result batch.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xmodem_crc_receiver_top_macros.svh"

module xcrc_step #(
    parameter int LONG_BLOCK_BYTES = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step_en,
    input  xcrc_pkg::item_t        item,
    input  logic [7:0]             max_errors,
    input  logic [31:0]            app_start_address,
    output xcrc_pkg::batch_t       batch
);

    localparam logic [xcrc_pkg::IDX_W-1:0] LONG_SIZE = xcrc_pkg::IDX_W'(LONG_BLOCK_BYTES);

    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_HEADER = 8'b0000_0010,
        PH_NUM    = 8'b0000_0100,
        PH_COMP   = 8'b0000_1000,
        PH_DATA   = 8'b0001_0000,
        PH_CRCH   = 8'b0010_0000,
        PH_CRCL   = 8'b0100_0000,
        PH_FLASH  = 8'b1000_0000
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [7:0]                 expected_reg, expected_next;
    logic [31:0]                waddr_reg, waddr_next;
    logic                       first_seen_reg, first_seen_next;
    logic [7:0]                 error_count_reg, error_count_next;
    logic [xcrc_pkg::IDX_W-1:0] byte_index_reg, byte_index_next;
    logic                       long_block_reg, long_block_next;
    logic [15:0]                crc_reg, crc_next;
    logic [7:0]                 crc_hi_reg, crc_hi_next;
    logic [7:0]                 block_num_reg, block_num_next;
    logic                       block_error_reg, block_error_next;

    logic [7:0]                 ec_inc;
    logic                       do_count;
    logic                       do_abort;
    logic [1:0]                 abort_code;
    logic [xcrc_pkg::IDX_W-1:0] idx_inc;
    logic [xcrc_pkg::IDX_W-1:0] blk_size;
    logic                       crc_bad;
    logic                       erase;
    logic [8:0]                 num_sum;

    // Protocol decode for one item
    always_comb
    begin
        phase_next       = phase_reg;
        expected_next    = expected_reg;
        waddr_next       = waddr_reg;
        first_seen_next  = first_seen_reg;
        error_count_next = error_count_reg;
        byte_index_next  = byte_index_reg;
        long_block_next  = long_block_reg;
        crc_next         = crc_reg;
        crc_hi_next      = crc_hi_reg;
        block_num_next   = block_num_reg;
        block_error_next = block_error_reg;
        batch            = '0;
        do_count         = 1'b0;
        do_abort         = 1'b0;
        abort_code       = xcrc_pkg::END_ERRORS;

        ec_inc   = (error_count_reg != xcrc_pkg::COUNT_MAX) ? error_count_reg + 8'd1
                                                            : error_count_reg;
        idx_inc  = byte_index_reg + 1'b1;
        blk_size = long_block_reg ? LONG_SIZE : xcrc_pkg::SHORT_BYTES;
        crc_bad  = block_error_reg || ({crc_hi_reg, item.rx_byte} != crc_reg);
        erase    = (waddr_reg == app_start_address);
        num_sum  = {1'b0, block_num_reg} + {1'b0, item.rx_byte};

        unique case (item.mode)
            xcrc_pkg::MODE_START:
            begin
                phase_next       = PH_HEADER;
                expected_next    = 8'd1;
                waddr_next       = app_start_address;
                first_seen_next  = 1'b0;
                error_count_next = 8'd0;
            end
            xcrc_pkg::MODE_TIMEOUT:
            begin
                if (phase_reg == PH_HEADER && !first_seen_reg)
                begin
                    batch.res[0] = xcrc_pkg::mk_tx(xcrc_pkg::B_C);
                    batch.count  = 2'd1;
                end
                else if (phase_reg != PH_IDLE && phase_reg != PH_FLASH)
                begin
                    do_count = 1'b1;
                end
            end
            xcrc_pkg::MODE_FLASH:
            begin
                if (phase_reg == PH_FLASH)
                begin
                    if (item.flash_ok)
                    begin
                        batch.res[0]  = xcrc_pkg::mk_tx(xcrc_pkg::B_ACK);
                        batch.count   = 2'd1;
                        expected_next = expected_reg + 8'd1;
                        waddr_next    = waddr_reg + 32'(blk_size);
                        phase_next    = PH_HEADER;
                    end
                    else
                    begin
                        error_count_next = (max_errors != xcrc_pkg::COUNT_MAX)
                                           ? max_errors + 8'd1 : xcrc_pkg::COUNT_MAX;
                        do_abort   = 1'b1;
                        abort_code = xcrc_pkg::END_FLASH;
                    end
                end
            end
            xcrc_pkg::MODE_BYTE:
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (item.rx_byte == xcrc_pkg::B_SOH || item.rx_byte == xcrc_pkg::B_STX)
                        begin
                            long_block_next  = (item.rx_byte == xcrc_pkg::B_STX);
                            byte_index_next  = '0;
                            crc_next         = 16'd0;
                            crc_hi_next      = 8'd0;
                            block_error_next = 1'b0;
                            phase_next       = PH_NUM;
                        end
                        else if (item.rx_byte == xcrc_pkg::B_EOT)
                        begin
                            batch.res[0] = xcrc_pkg::mk_tx(xcrc_pkg::B_ACK);
                            batch.res[1] = xcrc_pkg::mk_end(xcrc_pkg::END_DONE);
                            batch.count  = 2'd2;
                            phase_next   = PH_IDLE;
                        end
                        else if (item.rx_byte == xcrc_pkg::B_CAN)
                        begin
                            batch.res[0] = xcrc_pkg::mk_end(xcrc_pkg::END_CANCELLED);
                            batch.count  = 2'd1;
                            phase_next   = PH_IDLE;
                        end
                        else
                        begin
                            do_count = 1'b1;
                        end
                    end
                    PH_NUM:
                    begin
                        block_num_next = item.rx_byte;
                        phase_next     = PH_COMP;
                    end
                    PH_COMP:
                    begin
                        block_error_next = (block_num_reg != expected_reg) ||
                                           (num_sum != 9'd255);
                        phase_next       = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        batch.res[0].kind         = xcrc_pkg::KIND_STORE;
                        batch.res[0].store_byte   = item.rx_byte;
                        batch.res[0].store_offset = byte_index_reg[9:0];
                        batch.count               = 2'd1;
                        crc_next                  = xcrc_pkg::crc_byte(crc_reg, item.rx_byte);
                        byte_index_next           = idx_inc;
                        if (idx_inc >= blk_size)
                        begin
                            phase_next = PH_CRCH;
                        end
                    end
                    PH_CRCH:
                    begin
                        crc_hi_next = item.rx_byte;
                        phase_next  = PH_CRCL;
                    end
                    PH_CRCL:
                    begin
                        if (crc_bad)
                        begin
                            do_count = 1'b1;
                        end
                        else
                        begin
                            if (erase)
                            begin
                                first_seen_next = 1'b1;
                            end
                            batch.res[0].kind            = xcrc_pkg::KIND_PROG;
                            batch.res[0].program_address = waddr_reg;
                            batch.res[0].program_long    = long_block_reg;
                            batch.res[0].erase_first     = erase;
                            batch.count                  = 2'd1;
                            phase_next                   = PH_FLASH;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        // Error accounting: NAK, or abort at the limit
        if (do_count)
        begin
            error_count_next = ec_inc;
            if (ec_inc >= max_errors)
            begin
                do_abort = 1'b1;
            end
            else
            begin
                batch.res[0] = xcrc_pkg::mk_tx(xcrc_pkg::B_NAK);
                batch.count  = 2'd1;
                phase_next   = PH_HEADER;
            end
        end

        // Abort: CAN CAN, then session end
        if (do_abort)
        begin
            batch.res[0] = xcrc_pkg::mk_tx(xcrc_pkg::B_CAN);
            batch.res[1] = xcrc_pkg::mk_tx(xcrc_pkg::B_CAN);
            batch.res[2] = xcrc_pkg::mk_end(abort_code);
            batch.count  = 2'd3;
            phase_next   = PH_IDLE;
        end

        // Mark the final result
        for (int i = 0; i < xcrc_pkg::MAX_RES; i++)
        begin
            batch.res[i].last = (2'(i) == batch.count - 2'd1) && (batch.count != 2'd0);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            expected_reg    <= 8'd1;
            waddr_reg       <= xcrc_pkg::APP_START_RESET;
            first_seen_reg  <= 1'b0;
            error_count_reg <= 8'd0;
            byte_index_reg  <= '0;
            long_block_reg  <= 1'b0;
            block_error_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            expected_reg    <= expected_next;
            waddr_reg       <= waddr_next;
            first_seen_reg  <= first_seen_next;
            error_count_reg <= error_count_next;
            byte_index_reg  <= byte_index_next;
            long_block_reg  <= long_block_next;
            block_error_reg <= block_error_next;
        end
    end

    // Block payload: CRC and header bytes
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            crc_reg       <= crc_next;
            crc_hi_reg    <= crc_hi_next;
            block_num_reg <= block_num_next;
        end
    end

    `XCRC_ASSERT(a_phase_onehot, $onehot(phase_reg), "phase register not one-hot")
    `XCRC_ASSERT(a_index_bound, (phase_reg != PH_DATA) || (byte_index_reg < blk_size),
                 "data index ran past block size")
    `XCRC_ASSERT_NEXT(a_flash_hold,
                      step_en && phase_reg == PH_FLASH && item.mode != xcrc_pkg::MODE_START
                      && item.mode != xcrc_pkg::MODE_FLASH,
                      phase_reg == PH_FLASH, "left flash wait without a flash result")

endmodule

// ----- rtl/core/xcrc_outq.sv -----
// ---------------------------------------------------------------------------
// xcrc_outq
// Result register for one item's batch; sends it an item a cycle while ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xmodem_crc_receiver_top_macros.svh"

module xcrc_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  xcrc_pkg::batch_t  batch,
    output logic              free,
    xcrc_out_if.source        rslt
);

    xcrc_pkg::res_t [xcrc_pkg::MAX_RES-1:0] buf_reg;
    logic [1:0]                             rem_reg;
    logic [1:0]                             head_reg;
    xcrc_pkg::res_t                         cur;
    logic                                   pop;

    // Can take a new batch once the last held result leaves
    assign pop  = rslt.valid && rslt.ready;
    assign free = (rem_reg == 2'd0) || (rem_reg == 2'd1 && rslt.ready);
    assign cur  = buf_reg[head_reg];

    assign rslt.valid           = (rem_reg != 2'd0);
    assign rslt.kind            = cur.kind;
    assign rslt.tx_byte         = cur.tx_byte;
    assign rslt.store_byte      = cur.store_byte;
    assign rslt.store_offset    = cur.store_offset;
    assign rslt.program_address = cur.program_address;
    assign rslt.program_long    = cur.program_long;
    assign rslt.erase_first     = cur.erase_first;
    assign rslt.end_code        = cur.end_code;
    assign rslt.last            = cur.last;

    // Count and read pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= 2'd0;
            head_reg <= 2'd0;
        end
        else if (load)
        begin
            rem_reg  <= batch.count;
            head_reg <= 2'd0;
        end
        else if (pop)
        begin
            rem_reg  <= rem_reg - 2'd1;
            head_reg <= head_reg + 2'd1;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= batch.res;
        end
    end

    `XCRC_ASSERT(a_last_on_final, !rslt.valid || (rslt.last == (rem_reg == 2'd1)),
                 "last flag does not match remaining count")
    `XCRC_ASSERT(a_head_bound, (32'(head_reg) + 32'(rem_reg)) <= xcrc_pkg::MAX_RES,
                 "result pointer past batch end")
    `XCRC_ASSERT_NEXT(a_load_shows, load && batch.count != 2'd0, rslt.valid,
                      "loaded batch not presented")

endmodule

// ----- rtl/core/xmodem_crc_receiver_top.sv -----
// ---------------------------------------------------------------------------
// xmodem_crc_receiver_top
// XMODEM-CRC receiver: line and flash events in, line bytes and flash work out.
// ---------------------------------------------------------------------------
// Usage:
//   evt  : one item per event: session start, received byte, receive timeout
//          or flash result (with flash_ok).
//   rslt : zero to three items per event: byte to transmit, data byte with
//          its block offset, program request, or session end; last marks
//          the final item of one event.
//   cfg  : writes max_errors (index 0) and app_start_address (index 1);
//          always ready, write only while the receiver is idle.
// Path: an event taken on evt is registered; the CRC updates as its batch
//   loads into the result register, which presents its results on rslt.
// Throughput: one event per cycle while each event yields at most one
//   result and rslt is ready; an event with more results holds evt while
//   the single result register drains one item per cycle.
// Reset: session ended, waiting for a start event; config takes its
//   default values. No memory, so no clearing pass.
// Stall: when rslt is not taken, the result register and then the input
//   register fill and evt.ready drops; nothing is lost.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module xmodem_crc_receiver_top #(
    parameter int LONG_BLOCK_BYTES = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    xcrc_in_if.sink      evt,
    xcrc_out_if.source   rslt,
    xcrc_cfg_if.sink     cfg
);

    logic [7:0]             max_errors_reg;
    logic [31:0]            app_start_reg;
    xcrc_pkg::item_t        item_reg;
    logic                   item_valid_reg, item_valid_next;
    logic                   free;
    logic                   consume;
    logic                   take;
    xcrc_pkg::batch_t       batch;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_errors_reg <= xcrc_pkg::MAX_ERRORS_RESET;
            app_start_reg  <= xcrc_pkg::APP_START_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.wr_index)
                xcrc_pkg::CFG_MAX_ERRORS: max_errors_reg <= cfg.wr_data[7:0];
                xcrc_pkg::CFG_APP_START:  app_start_reg  <= cfg.wr_data;
                default: ;
            endcase
        end
    end

    // Input register
    assign consume   = item_valid_reg && free;
    assign evt.ready = !item_valid_reg || free;
    assign take      = evt.valid && evt.ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (take)
        begin
            item_valid_next = 1'b1;
        end
        else if (consume)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.mode     <= evt.mode;
            item_reg.rx_byte  <= evt.rx_byte;
            item_reg.flash_ok <= evt.flash_ok;
        end
    end

    // Protocol logic
    xcrc_step #(
        .LONG_BLOCK_BYTES (LONG_BLOCK_BYTES)
    ) u_step (
        .clk               (clk),
        .rst_n             (rst_n),
        .step_en           (consume),
        .item              (item_reg),
        .max_errors        (max_errors_reg),
        .app_start_address (app_start_reg),
        .batch             (batch)
    );

    // Result register
    xcrc_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (consume),
        .batch (batch),
        .free  (free),
        .rslt  (rslt)
    );

endmodule

// ----- bench/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the XMODEM-CRC receiver. A scoreboard class keeps
// its own copy of the session state, predicts the line bytes, staged data,
// program requests and session ends of every accepted item, and compares
// each result in order. Directed items come first, then phases of random
// sessions under several register settings and idle/stall patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import xcrc_pkg::*;

    localparam int LONG_BYTES = 1024;
    localparam int RAND_ITEMS = 330;
    localparam int N_PHASES   = 5;
    localparam int REPORT_CAP = 40;

    // Receiver phases as tracked by the scoreboard
    typedef enum logic [2:0] {
        ST_ENDED, ST_HEADER, ST_NUM, ST_COMP, ST_DATA, ST_CRC_HI, ST_CRC_LO, ST_FLASH
    } rx_phase_t;

    // Session scoreboard: predicted receiver state and results still due
    class xfer_scoreboard #(int BLK_LONG = 1024);
        logic [7:0]  max_err;
        logic [31:0] app_base;
        rx_phase_t   ph;
        logic [7:0]  exp_blk;
        logic [31:0] wr_addr;
        bit          first_seen;
        logic [7:0]  err_cnt;
        logic [10:0] idx;
        bit          long_blk;
        logic [15:0] crc;
        logic [15:0] rx_crc;
        logic [7:0]  blk_num;
        bit          blk_bad;
        res_t        due_results[$];
        res_t        step_out[$];
        int          errors;
        int          n_checked;
        int          n_programmed;

        function new();
            max_err    = MAX_ERRORS_RESET;
            app_base   = APP_START_RESET;
            ph         = ST_ENDED;
            exp_blk    = 8'd1;
            wr_addr    = APP_START_RESET;
            first_seen = 1'b0;
            err_cnt    = '0;
            idx        = '0;
            long_blk   = 1'b0;
            crc        = '0;
            rx_crc     = '0;
            blk_num    = '0;
            blk_bad    = 1'b0;
            errors     = 0;
            n_checked  = 0;
            n_programmed = 0;
        endfunction

        // CRC-16/XMODEM, one bit at a time through the feedback tap
        static function logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--)
            begin
                fb = c[15] ^ b[i];
                c = {c[14:0], 1'b0};
                if (fb)
                    c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        function void write_reg(input logic [0:0] ridx, input logic [31:0] val);
            if (ridx == CFG_MAX_ERRORS)
                max_err = val[7:0];
            else if (ridx == CFG_APP_START)
                app_base = val;
        endfunction

        function int blk_len();
            return long_blk ? BLK_LONG : int'(SHORT_BYTES);
        endfunction

        function void emit_tx(input logic [7:0] b);
            res_t r;
            r = '0;
            r.kind = KIND_TX;
            r.tx_byte = b;
            step_out.push_back(r);
        endfunction

        function void emit_end(input logic [1:0] code);
            res_t r;
            r = '0;
            r.kind = KIND_END;
            r.end_code = code;
            step_out.push_back(r);
        endfunction

        function void abort_session(input logic [1:0] code);
            emit_tx(B_CAN);
            emit_tx(B_CAN);
            emit_end(code);
            ph = ST_ENDED;
        endfunction

        function void count_error();
            if (err_cnt != COUNT_MAX)
                err_cnt = err_cnt + 8'd1;
            if (err_cnt >= max_err)
                abort_session(END_ERRORS);
            else
            begin
                emit_tx(B_NAK);
                ph = ST_HEADER;
            end
        endfunction

        // Serial byte, by phase of the block
        function void take_byte(input logic [7:0] b);
            res_t r;
            bit   erase;
            r = '0;
            case (ph)
                ST_HEADER:
                begin
                    if (b == B_SOH || b == B_STX)
                    begin
                        long_blk = (b == B_STX);
                        idx      = '0;
                        crc      = '0;
                        rx_crc   = '0;
                        blk_bad  = 1'b0;
                        ph       = ST_NUM;
                    end
                    else if (b == B_EOT)
                    begin
                        emit_tx(B_ACK);
                        emit_end(END_DONE);
                        ph = ST_ENDED;
                    end
                    else if (b == B_CAN)
                    begin
                        emit_end(END_CANCELLED);
                        ph = ST_ENDED;
                    end
                    else
                        count_error();
                end
                ST_NUM:
                begin
                    blk_num = b;
                    ph = ST_COMP;
                end
                ST_COMP:
                begin
                    blk_bad = (blk_num != exp_blk) || ({1'b0, blk_num} + {1'b0, b} != 9'd255);
                    ph = ST_DATA;
                end
                ST_DATA:
                begin
                    r.kind = KIND_STORE;
                    r.store_byte = b;
                    r.store_offset = idx[9:0];
                    step_out.push_back(r);
                    crc = crc_next(crc, b);
                    idx = idx + 11'd1;
                    if (int'(idx) >= blk_len())
                        ph = ST_CRC_HI;
                end
                ST_CRC_HI:
                begin
                    rx_crc = {b, 8'h00};
                    ph = ST_CRC_LO;
                end
                ST_CRC_LO:
                begin
                    rx_crc[7:0] = b;
                    if (blk_bad || rx_crc != crc)
                        count_error();
                    else
                    begin
                        erase = (wr_addr == app_base);
                        if (erase)
                            first_seen = 1'b1;
                        r.kind = KIND_PROG;
                        r.program_address = wr_addr;
                        r.program_long = long_blk;
                        r.erase_first = erase;
                        step_out.push_back(r);
                        n_programmed++;
                        ph = ST_FLASH;
                    end
                end
                default: ;
            endcase
        endfunction

        // Predict the results of one accepted item
        function void take_event(input item_t it);
            res_t r;
            step_out.delete();
            case (it.mode)
                MODE_START:
                begin
                    ph         = ST_HEADER;
                    exp_blk    = 8'd1;
                    wr_addr    = app_base;
                    first_seen = 1'b0;
                    err_cnt    = '0;
                end
                MODE_TIMEOUT:
                begin
                    if (ph == ST_HEADER && !first_seen)
                        emit_tx(B_C);
                    else if (ph != ST_ENDED && ph != ST_FLASH)
                        count_error();
                end
                MODE_FLASH:
                begin
                    if (ph == ST_FLASH)
                    begin
                        if (it.flash_ok)
                        begin
                            emit_tx(B_ACK);
                            exp_blk = exp_blk + 8'd1;
                            wr_addr = wr_addr + 32'(blk_len());
                            ph = ST_HEADER;
                        end
                        else
                        begin
                            err_cnt = (max_err != COUNT_MAX) ? max_err + 8'd1 : COUNT_MAX;
                            abort_session(END_FLASH);
                        end
                    end
                end
                default: take_byte(it.rx_byte);
            endcase
            // last marks the final result of the item
            if (step_out.size() > 0)
            begin
                r = step_out.pop_back();
                r.last = 1'b1;
                step_out.push_back(r);
            end
            foreach (step_out[i])
                due_results.push_back(step_out[i]);
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= REPORT_CAP)
                $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        task match_result(input res_t got);
            res_t  want;
            string diffs;
            if (due_results.size() == 0)
            begin
                report($sformatf("result with nothing due: %h", got));
                return;
            end
            want = due_results.pop_front();
            n_checked++;
            diffs = "";
            if (got.kind !== want.kind)                       diffs = {diffs, " kind"};
            if (got.tx_byte !== want.tx_byte)                 diffs = {diffs, " tx_byte"};
            if (got.store_byte !== want.store_byte)           diffs = {diffs, " store_byte"};
            if (got.store_offset !== want.store_offset)       diffs = {diffs, " store_offset"};
            if (got.program_address !== want.program_address) diffs = {diffs, " program_address"};
            if (got.program_long !== want.program_long)       diffs = {diffs, " program_long"};
            if (got.erase_first !== want.erase_first)         diffs = {diffs, " erase_first"};
            if (got.end_code !== want.end_code)               diffs = {diffs, " end_code"};
            if (got.last !== want.last)                       diffs = {diffs, " last"};
            if (diffs != "")
                report($sformatf("result %0d differs in%s: got %h, expected %h",
                                 n_checked, diffs, got, want));
        endtask
    endclass

    logic clk;
    logic rst_n;

    xcrc_in_if  evt();
    xcrc_out_if rslt();
    xcrc_cfg_if cfg();

    xmodem_crc_receiver_top #(.LONG_BLOCK_BYTES(LONG_BYTES)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .rslt  (rslt),
        .cfg   (cfg)
    );

    xfer_scoreboard #(LONG_BYTES) sb;

    int src_idle_pct;
    int sink_stall_pct;
    bit evt_up;
    int n_items;
    int n_sessions;

    // Clock
    initial
        clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // Result side: random stalls, decided at the falling edge
    initial
    begin
        rslt.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            rslt.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Result check at the rising edge
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && rslt.valid && rslt.ready)
        begin
            got.kind            = rslt.kind;
            got.tx_byte         = rslt.tx_byte;
            got.store_byte      = rslt.store_byte;
            got.store_offset    = rslt.store_offset;
            got.program_address = rslt.program_address;
            got.program_long    = rslt.program_long;
            got.erase_first     = rslt.erase_first;
            got.end_code        = rslt.end_code;
            got.last            = rslt.last;
            sb.match_result(got);
        end
    end

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom_range(1));
    endfunction

    // Any byte that is not a valid header byte
    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do
            b = rnd_byte();
        while (b == B_SOH || b == B_STX || b == B_EOT || b == B_CAN);
        return b;
    endfunction

    task automatic drop_evt_valid();
        if (evt_up)
        begin
            evt.valid <= 1'b0;
            evt_up = 1'b0;
        end
    endtask

    // Send one item; entered and left at a falling edge
    task automatic send_evt(input logic [1:0] m, input logic [7:0] b, input logic ok);
        item_t it;
        int    gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            drop_evt_valid();
            repeat (gap) @(negedge clk);
        end
        evt.valid    <= 1'b1;
        evt.mode     <= m;
        evt.rx_byte  <= b;
        evt.flash_ok <= ok;
        evt_up = 1'b1;
        do
            @(posedge clk);
        while (!evt.ready);
        it.mode     = m;
        it.rx_byte  = b;
        it.flash_ok = ok;
        sb.take_event(it);
        n_items++;
        @(negedge clk);
    endtask

    // One block: header, number, complement, data, CRC. A cut replaces the
    // byte at that stream position by a timeout or a restart, and ends there.
    task automatic send_block(input bit lng, input logic [7:0] num, input logic [7:0] comp,
                              input bit bad_crc, input int cut_at, input bit cut_start);
        logic [7:0]  stream[$];
        logic [7:0]  d;
        logic [15:0] c;
        int          len;
        len = lng ? LONG_BYTES : int'(SHORT_BYTES);
        c = '0;
        stream.push_back(num);
        stream.push_back(comp);
        for (int i = 0; i < len; i++)
        begin
            d = rnd_byte();
            stream.push_back(d);
            c = sb.crc_next(c, d);
        end
        if (bad_crc)
            c = c ^ 16'(1 << $urandom_range(15));
        stream.push_back(c[15:8]);
        stream.push_back(c[7:0]);
        send_evt(MODE_BYTE, lng ? B_STX : B_SOH, rnd_bit());
        foreach (stream[i])
        begin
            if (i == cut_at)
            begin
                send_evt(cut_start ? MODE_START : MODE_TIMEOUT, rnd_byte(), rnd_bit());
                return;
            end
            send_evt(MODE_BYTE, stream[i], rnd_bit());
        end
    endtask

    task automatic good_block(input bit lng);
        send_block(lng, sb.exp_blk, ~sb.exp_blk, 1'b0, -1, 1'b0);
    endtask

    // Flash result for a pending program request, sometimes after noise
    task automatic answer_flash(input int fail_pct);
        if (sb.ph != ST_FLASH)
            return;
        if ($urandom_range(99) < 30)
            send_evt(rnd_bit() ? MODE_BYTE : MODE_TIMEOUT, rnd_byte(), rnd_bit());
        send_evt(MODE_FLASH, rnd_byte(), $urandom_range(99) >= fail_pct);
    endtask

    // Random session: well-formed blocks most often, some broken ones and noise
    task automatic run_session(input int n_acts);
        int         sel;
        logic [7:0] num;
        n_sessions++;
        send_evt(MODE_START, rnd_byte(), rnd_bit());
        repeat (n_acts)
        begin
            if (sb.ph == ST_ENDED)
                break;
            sel = $urandom_range(99);
            num = sb.exp_blk;
            if (sel < 40)
            begin
                good_block(1'b0);
                answer_flash(8);
            end
            else if (sel < 48)
                send_block(1'b0, num, ~num, 1'b1, -1, 1'b0);
            else if (sel < 54)
                send_block(1'b0, num - 8'd1, ~(num - 8'd1), 1'b0, -1, 1'b0);
            else if (sel < 60)
                send_block(1'b0, num, ~num ^ 8'(1 << $urandom_range(7)), 1'b0, -1, 1'b0);
            else if (sel < 70)
                send_block(1'b0, num, ~num, 1'b0, $urandom_range(131), 1'b0);
            else if (sel < 78)
                send_evt(MODE_BYTE, junk_byte(), rnd_bit());
            else if (sel < 86)
                send_evt(MODE_TIMEOUT, rnd_byte(), rnd_bit());
            else if (sel < 90)
                send_evt(MODE_FLASH, rnd_byte(), rnd_bit());
            else if (sel < 94)
                send_evt(MODE_BYTE, B_CAN, rnd_bit());
            else
                send_block(1'b0, num, ~num, 1'b0, $urandom_range(131), 1'b1);
        end
        if (sb.ph == ST_HEADER && $urandom_range(3) != 0)
            send_evt(MODE_BYTE, B_EOT, rnd_bit());
    endtask

    // Wait until every predicted result has come out, then let the pipe empty
    task automatic wait_drained();
        int guard;
        drop_evt_valid();
        guard = 0;
        while (sb.due_results.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic set_regs(input logic [7:0] me, input logic [31:0] base);
        cfg.valid    <= 1'b1;
        cfg.wr_index <= CFG_MAX_ERRORS;
        cfg.wr_data  <= {24'd0, me};
        do
            @(posedge clk);
        while (!cfg.ready);
        sb.write_reg(CFG_MAX_ERRORS, {24'd0, me});
        @(negedge clk);
        cfg.wr_index <= CFG_APP_START;
        cfg.wr_data  <= base;
        do
            @(posedge clk);
        while (!cfg.ready);
        sb.write_reg(CFG_APP_START, base);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Short directed run on the reset settings
    task automatic directed_run();
        // events while ended are ignored
        send_evt(MODE_BYTE, B_SOH, 1'b1);
        send_evt(MODE_TIMEOUT, 8'hFF, 1'b0);
        send_evt(MODE_FLASH, 8'h00, 1'b1);
        send_evt(MODE_FLASH, 8'hFF, 1'b0);
        // 'C' before the first block, stray flash result, errors up to abort
        send_evt(MODE_START, 8'h00, 1'b0);
        send_evt(MODE_TIMEOUT, 8'h00, 1'b1);
        send_evt(MODE_FLASH, 8'h55, 1'b1);
        send_evt(MODE_BYTE, 8'hFF, 1'b0);
        send_evt(MODE_BYTE, 8'h00, 1'b1);
        send_evt(MODE_BYTE, 8'hAA, 1'b0);
        // host cancel
        send_evt(MODE_START, 8'hFF, 1'b1);
        send_evt(MODE_BYTE, B_CAN, 1'b0);
        // end of transfer
        send_evt(MODE_START, 8'h00, 1'b0);
        send_evt(MODE_BYTE, B_EOT, 1'b1);
        // timeout inside a block, restart inside a block
        send_evt(MODE_START, 8'h00, 1'b0);
        send_evt(MODE_BYTE, B_STX, 1'b0);
        send_evt(MODE_BYTE, 8'h01, 1'b0);
        send_evt(MODE_TIMEOUT, 8'h00, 1'b0);
        send_evt(MODE_BYTE, B_SOH, 1'b1);
        send_evt(MODE_START, 8'h00, 1'b1);
        send_evt(MODE_BYTE, B_EOT, 1'b0);
    endtask

    // Main sequence
    initial
    begin
        logic [7:0]  me;
        logic [31:0] base;
        int          phase_start;
        sb = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        evt_up         = 1'b0;
        n_items        = 0;
        n_sessions     = 0;
        rst_n          <= 1'b0;
        evt.valid      <= 1'b0;
        evt.mode       <= MODE_START;
        evt.rx_byte    <= 8'h00;
        evt.flash_ok   <= 1'b0;
        cfg.valid      <= 1'b0;
        cfg.wr_index   <= CFG_MAX_ERRORS;
        cfg.wr_data    <= '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_run();

        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_drained();
            case (p)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  me = 8'd3;   base = 32'h0800_0000; end
                1: begin src_idle_pct = 87; sink_stall_pct = 0;  me = 8'd1;   base = 32'hFFFF_FF80; end
                2: begin src_idle_pct = 0;  sink_stall_pct = 87; me = 8'd255; base = 32'h0000_0000; end
                3: begin src_idle_pct = 26; sink_stall_pct = 26; me = 8'd0;   base = 32'hFFFF_FFFF; end
                default:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                    me = 8'($urandom_range(8, 2));
                    base = $urandom;
                end
            endcase
            set_regs(me, base);
            @(negedge clk);
            phase_start = n_items;

            // scripted session for each of the first three phases
            case (p)
                0:
                begin
                    // one full long block, then a short one
                    n_sessions++;
                    send_evt(MODE_START, rnd_byte(), rnd_bit());
                    good_block(1'b1);
                    answer_flash(0);
                    good_block(1'b0);
                    answer_flash(0);
                    send_evt(MODE_BYTE, B_EOT, rnd_bit());
                end
                1:
                begin
                    // address wraps past the top; second program fails
                    n_sessions++;
                    send_evt(MODE_START, rnd_byte(), rnd_bit());
                    good_block(1'b0);
                    answer_flash(0);
                    good_block(1'b0);
                    answer_flash(100);
                end
                2:
                begin
                    // error count runs all the way to the top limit
                    n_sessions++;
                    send_evt(MODE_START, rnd_byte(), rnd_bit());
                    repeat (257)
                        send_evt(MODE_BYTE, junk_byte(), rnd_bit());
                end
                default: ;
            endcase

            while (n_items - phase_start < RAND_ITEMS / N_PHASES)
                run_session($urandom_range(6, 2));
        end

        wait_drained();
        if (sb.due_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.due_results.size()));
        $display("Ran %0d items in %0d sessions under %0d register settings and idle patterns.",
                 n_items, n_sessions, N_PHASES + 1);
        $display("Checked %0d results, %0d of them program requests.",
                 sb.n_checked, sb.n_programmed);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/xcrc_pkg.sv
rtl/core/xcrc_if.sv
rtl/core/xcrc_step.sv
rtl/core/xcrc_outq.sv
rtl/core/xmodem_crc_receiver_top.sv
bench/testbench.sv
